FILE: rtl/lru_cache_with_periodic_eviction_top_assert.svh
// assertion macros used by the cache sequencer rtl
`ifndef LRU_CACHE_WITH_PERIODIC_EVICTION_TOP_ASSERT_SVH
`define LRU_CACHE_WITH_PERIODIC_EVICTION_TOP_ASSERT_SVH

// expression holds at every edge outside reset
`define LRUPE_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define LRUPE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRUPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lrupe_pkg.sv
`default_nettype none

package lrupe_pkg;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam int CAP_W  = 5;
   localparam int INTV_W = 16;
   localparam int CSR_W  = 16;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [INTV_W-1:0] INTV_RESET = 16'd0;

   // request kinds
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // csr register indexes
   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic CSR_IDX_BURNOUT  = 1'b1;

   localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_APPLY,
      ST_UPDATE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic                    kind;
      logic signed [KEY_W-1:0] lookup_key;
      logic signed [VAL_W-1:0] put_value;
   } req_item_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
   } rsp_item_type;

   typedef struct packed {
      logic key_we;
      logic val_we;
      logic rank_we;
   } mem_we_type;

endpackage

`default_nettype wire

FILE: rtl/lrupe_req_if.sv
`default_nettype none

interface lrupe_req_if;
   import lrupe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic signed [KEY_W-1:0] lookup_key;
   logic signed [VAL_W-1:0] put_value;

   modport source (output valid, kind, lookup_key, put_value, input ready);
   modport sink   (input valid, kind, lookup_key, put_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrupe_rsp_if.sv
`default_nettype none

interface lrupe_rsp_if;
   import lrupe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrupe_entry_mem.sv
`default_nettype none

module lrupe_entry_mem #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  wire                      clock,
   input  lrupe_pkg::mem_we_type    mem_we,
   input  wire [IDX_W-1:0]          wr_addr,
   input  wire [lrupe_pkg::KEY_W-1:0] wr_key,
   input  wire [lrupe_pkg::VAL_W-1:0] wr_val,
   input  wire [IDX_W-1:0]          wr_rank,
   input  wire [IDX_W-1:0]          rd_addr,
   output logic [lrupe_pkg::KEY_W-1:0] rd_key,
   output logic [lrupe_pkg::VAL_W-1:0] rd_val,
   output logic [IDX_W-1:0]         rd_rank
);
   import lrupe_pkg::*;

   logic [KEY_W-1:0] key_mem  [ENTRIES];
   logic [VAL_W-1:0] val_mem  [ENTRIES];
   logic [IDX_W-1:0] rank_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (mem_we.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (mem_we.val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
      if (mem_we.rank_we) begin
         rank_mem[wr_addr] <= wr_rank;
      end
   end

   // registered read, one address for all three arrays
   always_ff @(posedge clock) begin
      rd_key  <= key_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
      rd_rank <= rank_mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/lrupe_ctrl.sv
`default_nettype none
`include "lru_cache_with_periodic_eviction_top_assert.svh"

module lrupe_ctrl #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4,
   parameter int CNT_W   = 5
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  lrupe_pkg::req_item_type      req_item,
   input  wire [lrupe_pkg::CAP_W-1:0]   cap_limit,
   input  wire [lrupe_pkg::INTV_W-1:0]  burn_intv,
   input  wire                          out_free,
   output logic                         res_valid,
   output lrupe_pkg::rsp_item_type      res_item,
   output lrupe_pkg::mem_we_type        mem_we,
   output logic [IDX_W-1:0]             mem_rd_addr,
   output logic [IDX_W-1:0]             mem_wr_addr,
   output logic [lrupe_pkg::KEY_W-1:0]  mem_wr_key,
   output logic [lrupe_pkg::VAL_W-1:0]  mem_wr_val,
   output logic [IDX_W-1:0]             mem_wr_rank,
   input  wire [lrupe_pkg::KEY_W-1:0]   mem_rd_key,
   input  wire [lrupe_pkg::VAL_W-1:0]   mem_rd_val,
   input  wire [IDX_W-1:0]              mem_rd_rank
);
   import lrupe_pkg::*;

   localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);
   localparam int CMP_W = CNT_W + CAP_W;

   ctrl_state_type state_ff, state_in;
   req_item_type   item_ff, item_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   hit_rank_ff, hit_rank_in;
   logic [VAL_W-1:0]   hit_val_ff, hit_val_in;
   logic [IDX_W-1:0]   lru_ff, lru_in;
   logic               lru_found_ff, lru_found_in;
   logic [IDX_W-1:0]   free_ff, free_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   burn_ff, burn_in;
   logic               burn_found_ff, burn_found_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [INTV_W-1:0]  reqcnt_ff, reqcnt_in;

   // scan datapath
   logic [CNT_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  p_idx;
   logic              data_ok;
   logic              cur_valid;
   logic [CNT_W-1:0]  occ_m1;
   logic [IDX_W-1:0]  new_rank;
   logic [CMP_W-1:0]  cap_ext, eff_cap;
   logic              evict;
   logic [IDX_W-1:0]  ins_slot;
   logic              slot_ok;
   logic [INTV_W:0]   reqcnt_p1;
   logic              burn_fire;
   logic              is_put;

   always_comb begin
      cnt_m1    = cnt_ff - CNT_W'(1);
      p_idx     = cnt_m1[IDX_W-1:0];
      data_ok   = (cnt_ff != '0);
      cur_valid = data_ok && valid_ff[p_idx];
      occ_m1    = occ_ff - CNT_W'(1);
      is_put    = (item_ff.kind == KIND_PUT);

      // recency after this request
      if (p_idx == slot_ff) begin
         new_rank = '0;
      end else if (hit_ff) begin
         new_rank = (mem_rd_rank < hit_rank_ff) ? mem_rd_rank + IDX_W'(1) : mem_rd_rank;
      end else begin
         new_rank = mem_rd_rank + IDX_W'(1);
      end

      // effective capacity, clamped to one and to the entry count
      cap_ext = CMP_W'(cap_limit);
      if (cap_limit == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      evict = (CMP_W'(occ_ff) >= eff_cap) && lru_found_ff;

      // lowest free slot once the victim is gone
      if (evict && (!free_found_ff || (lru_ff < free_ff))) begin
         ins_slot = lru_ff;
      end else begin
         ins_slot = free_ff;
      end
      slot_ok = evict || free_found_ff;

      reqcnt_p1 = {1'b0, reqcnt_ff} + (INTV_W+1)'(1);
      burn_fire = (burn_intv != '0) && (reqcnt_p1 >= {1'b0, burn_intv});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cnt_ff == LAST) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (hit_ff) begin
               state_in = ST_UPDATE;
            end else if (is_put) begin
               state_in = ST_APPLY;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_APPLY: begin
            state_in = slot_ok ? ST_UPDATE : ST_DONE;
         end
         ST_UPDATE: begin
            if (cnt_ff == LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (is_put || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready           = (state_ff == ST_IDLE);
      res_valid           = (state_ff == ST_DONE) && !is_put && out_free;
      res_item.hit        = hit_ff;
      res_item.read_value = hit_ff ? hit_val_ff : MISS_VALUE;
      mem_we              = '0;
      mem_rd_addr         = (cnt_ff == LAST) ? '0 : cnt_ff[IDX_W-1:0];
      mem_wr_addr         = p_idx;
      mem_wr_key          = item_ff.lookup_key;
      mem_wr_val          = item_ff.put_value;
      mem_wr_rank         = new_rank;
      case (state_ff)
         ST_DECIDE: begin
            mem_wr_addr   = slot_ff;
            mem_we.val_we = hit_ff && is_put;
         end
         ST_APPLY: begin
            mem_wr_addr   = ins_slot;
            mem_we.key_we = slot_ok;
            mem_we.val_we = slot_ok;
         end
         ST_UPDATE: begin
            mem_we.rank_we = cur_valid;
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_val_in    = hit_val_ff;
      lru_in        = lru_ff;
      lru_found_in  = lru_found_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      burn_in       = burn_ff;
      burn_found_in = burn_found_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      reqcnt_in     = reqcnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in       = req_item;
               cnt_in        = '0;
               hit_in        = 1'b0;
               lru_found_in  = 1'b0;
               free_found_in = 1'b0;
               burn_found_in = 1'b0;
            end
         end
         ST_LOOKUP: begin
            cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + CNT_W'(1);
            if (cur_valid && (mem_rd_key == item_ff.lookup_key) && !hit_ff) begin
               hit_in      = 1'b1;
               slot_in     = p_idx;
               hit_rank_in = mem_rd_rank;
               hit_val_in  = mem_rd_val;
            end
            if (cur_valid && (mem_rd_rank == occ_m1[IDX_W-1:0])) begin
               lru_in       = p_idx;
               lru_found_in = 1'b1;
            end
            if (data_ok && !valid_ff[p_idx] && !free_found_ff) begin
               free_in       = p_idx;
               free_found_in = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!hit_ff && !is_put) begin
               burn_in       = lru_ff;
               burn_found_in = lru_found_ff;
            end
         end
         ST_APPLY: begin
            if (slot_ok) begin
               if (evict) begin
                  valid_in[lru_ff] = 1'b0;
               end
               valid_in[ins_slot] = 1'b1;
               slot_in            = ins_slot;
               occ_in             = evict ? occ_ff : occ_ff + CNT_W'(1);
            end else begin
               burn_in       = lru_ff;
               burn_found_in = lru_found_ff;
            end
         end
         ST_UPDATE: begin
            cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + CNT_W'(1);
            if (cur_valid && (new_rank == occ_m1[IDX_W-1:0])) begin
               burn_in       = p_idx;
               burn_found_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (is_put || out_free) begin
               if (burn_intv == '0) begin
                  reqcnt_in = '0;
               end else if (burn_fire) begin
                  reqcnt_in = '0;
                  if (burn_found_ff) begin
                     valid_in[burn_ff] = 1'b0;
                     occ_in            = occ_ff - CNT_W'(1);
                  end
               end else begin
                  reqcnt_in = reqcnt_p1[INTV_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         valid_ff  <= '0;
         occ_ff    <= '0;
         reqcnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= valid_in;
         occ_ff    <= occ_in;
         reqcnt_ff <= reqcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      hit_rank_ff   <= hit_rank_in;
      hit_val_ff    <= hit_val_in;
      lru_ff        <= lru_in;
      lru_found_ff  <= lru_found_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      burn_ff       <= burn_in;
      burn_found_ff <= burn_found_in;
   end

   `LRUPE_ASSERT_HOLDS(a_occ_matches_valid, clock, reset, occ_ff == CNT_W'($countones(valid_ff)), "occupancy differs from valid count")
   `LRUPE_ASSERT_HOLDS(a_occ_bound, clock, reset, occ_ff <= LAST, "occupancy above entry count")
   `LRUPE_ASSERT_IMPLIES(a_result_room, clock, reset, res_valid, out_free, "result issued into busy output")
   `LRUPE_ASSERT_NEXT(a_accept_scans, clock, reset, req_valid && req_ready, state_ff == ST_LOOKUP, "accepted request did not start scan")

endmodule

`default_nettype wire

FILE: rtl/lru_cache_with_periodic_eviction_top.sv
// channel   dir  handshake                    payload
// req_ch    in   valid/ready                  kind, lookup_key, put_value
// rsp_ch    out  valid/ready                  hit, read_value (one per get)
// csr       in   csr_write_enable (no ready)  csr_index, csr_write_data
//
// a request scans the entry memories one entry per cycle through a single read port
// get miss: lookup scan only; hit: lookup and recency scans; put miss: lookup, insert, recency scan
// req ready only while the sequencer is idle; a held result does not block the next request
// a get result stalls the sequencer only if the output register is still full
// synchronous reset clears valid bits, occupancy and counters; no memory clearing pass
`default_nettype none

module lru_cache_with_periodic_eviction_top #(
   parameter int CACHE_ENTRIES = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   lrupe_req_if.sink                       req_ch,
   lrupe_rsp_if.source                     rsp_ch,
   input  wire                             csr_write_enable,
   input  wire                             csr_index,
   input  wire [lrupe_pkg::CSR_W-1:0]      csr_write_data
);
   import lrupe_pkg::*;

   // entry index and rank width, count width covers a full store
   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

   // configuration registers
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [INTV_W-1:0] intv_ff, intv_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   req_item_type req_item;
   logic         req_ready;
   logic         out_free;
   logic         res_valid;
   rsp_item_type res_item;

   // memory port
   mem_we_type       mem_we;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [KEY_W-1:0] mem_wr_key;
   logic [VAL_W-1:0] mem_wr_val;
   logic [IDX_W-1:0] mem_wr_rank;
   logic [KEY_W-1:0] mem_rd_key;
   logic [VAL_W-1:0] mem_rd_val;
   logic [IDX_W-1:0] mem_rd_rank;

   // request payload into the sequencer
   always_comb begin
      req_item.kind       = req_ch.kind;
      req_item.lookup_key = req_ch.lookup_key;
      req_item.put_value  = req_ch.put_value;
   end
   assign req_ch.ready = req_ready;

   // csr writes, to be made only while idle by convention; the block does not enforce it
   always_comb begin
      cap_in  = cap_ff;
      intv_in = intv_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IDX_CAPACITY: cap_in  = csr_write_data[CAP_W-1:0];
            CSR_IDX_BURNOUT:  intv_in = csr_write_data[INTV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         intv_ff <= INTV_RESET;
      end else begin
         cap_ff  <= cap_in;
         intv_ff <= intv_in;
      end
   end

   // output register frees when its transfer completes
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_item_ff.hit;
   assign rsp_ch.read_value = rsp_item_ff.read_value;

   // sequencer: lookup scan, recency update scan, eviction and burnout
   lrupe_ctrl #(
      .ENTRIES (CACHE_ENTRIES),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .cap_limit   (cap_ff),
      .burn_intv   (intv_ff),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res_item    (res_item),
      .mem_we      (mem_we),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_key  (mem_wr_key),
      .mem_wr_val  (mem_wr_val),
      .mem_wr_rank (mem_wr_rank),
      .mem_rd_key  (mem_rd_key),
      .mem_rd_val  (mem_rd_val),
      .mem_rd_rank (mem_rd_rank)
   );

   // key, value and recency storage
   lrupe_entry_mem #(
      .ENTRIES (CACHE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_entry_mem (
      .clock   (clock),
      .mem_we  (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_key  (mem_wr_key),
      .wr_val  (mem_wr_val),
      .wr_rank (mem_wr_rank),
      .rd_addr (mem_rd_addr),
      .rd_key  (mem_rd_key),
      .rd_val  (mem_rd_val),
      .rd_rank (mem_rd_rank)
   );

endmodule

`default_nettype wire

FILE: sim/lru_cache_with_periodic_eviction_checker.sv
`timescale 1ns / 100ps

module lru_cache_with_periodic_eviction_checker #(
   parameter int CACHE_ENTRIES = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   lrupe_req_if                       req_ch,
   lrupe_rsp_if                       rsp_ch,
   input  wire                        csr_write_enable,
   input  wire                        csr_index,
   input  wire [lrupe_pkg::CSR_W-1:0] csr_write_data,
   output int                         mismatch_count,
   output int                         results_outstanding
);
   import lrupe_pkg::*;

   // shadow copy of the cache contents
   logic [KEY_W-1:0]  slot_key   [CACHE_ENTRIES];
   logic [VAL_W-1:0]  slot_value [CACHE_ENTRIES];
   bit                slot_live  [CACHE_ENTRIES];
   int                slot_age   [CACHE_ENTRIES];
   int                live_count;
   int                request_tally;
   logic [CAP_W-1:0]  capacity_reg;
   logic [INTV_W-1:0] burnout_reg;

   rsp_item_type      lookup_results_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic int find_slot(input logic [KEY_W-1:0] key);
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (slot_live[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   function automatic void evict_oldest();
      int victim;
      int worst;
      victim = -1;
      worst  = 0;
      // ties go to the highest index
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (slot_live[i] && (victim < 0 || slot_age[i] >= worst)) begin
            victim = i;
            worst  = slot_age[i];
         end
      end
      if (victim >= 0) begin
         slot_live[victim] = 1'b0;
         if (live_count > 0)
            live_count--;
      end
   endfunction

   function automatic void promote(input int slot);
      int r;
      r = slot_age[slot];
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (slot_live[i] && i != slot && slot_age[i] < r)
            slot_age[i]++;
      slot_age[slot] = 0;
   endfunction

   function automatic int usable_capacity();
      if (capacity_reg == 0)
         return 1;
      if (capacity_reg > CACHE_ENTRIES)
         return CACHE_ENTRIES;
      return capacity_reg;
   endfunction

   function automatic void store_pair(input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] value);
      int slot;
      slot = -1;
      if (live_count >= usable_capacity())
         evict_oldest();
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (slot < 0 && !slot_live[i])
            slot = i;
      if (slot < 0)
         return;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (slot_live[i])
            slot_age[i]++;
      slot_key[slot]   = key;
      slot_value[slot] = value;
      slot_live[slot]  = 1'b1;
      slot_age[slot]   = 0;
      live_count++;
   endfunction

   function automatic void burnout_step();
      if (burnout_reg == 0) begin
         request_tally = 0;
         return;
      end
      if (request_tally + 1 >= burnout_reg) begin
         request_tally = 0;
         evict_oldest();
      end else begin
         request_tally++;
      end
   endfunction

   function automatic void serve_request(input req_item_type item);
      int           slot;
      rsp_item_type res;
      slot = find_slot(item.lookup_key);
      if (item.kind == KIND_PUT) begin
         if (slot >= 0) begin
            slot_value[slot] = item.put_value;
            promote(slot);
         end else begin
            store_pair(item.lookup_key, item.put_value);
         end
      end else begin
         if (slot >= 0) begin
            promote(slot);
            res.hit        = 1'b1;
            res.read_value = slot_value[slot];
         end else begin
            res.hit        = 1'b0;
            res.read_value = MISS_VALUE;
         end
         lookup_results_q.push_back(res);
      end
      burnout_step();
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      req_item_type item;
      if (reset) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
         end
         live_count    = 0;
         request_tally = 0;
         capacity_reg  = CAP_RESET;
         burnout_reg   = INTV_RESET;
         lookup_results_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (lookup_results_q.size() == 0) begin
               report_mismatch("result with no pending get", rsp_ch.read_value, '0);
            end else begin
               want = lookup_results_q.pop_front();
               if (rsp_ch.hit !== want.hit)
                  report_mismatch("hit", rsp_ch.hit, want.hit);
               if (rsp_ch.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_ch.read_value, want.read_value);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            item.kind       = req_ch.kind;
            item.lookup_key = req_ch.lookup_key;
            item.put_value  = req_ch.put_value;
            serve_request(item);
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_IDX_CAPACITY)
               capacity_reg = csr_write_data[CAP_W-1:0];
            else
               burnout_reg = csr_write_data[INTV_W-1:0];
         end
      end
      results_outstanding <= lookup_results_q.size();
   end

endmodule

FILE: sim/tb_lru_cache_with_periodic_eviction_top.sv
`timescale 1ns / 100ps

module tb_lru_cache_with_periodic_eviction_top;
   import lrupe_pkg::*;

   localparam int CACHE_ENTRIES   = 16;
   // worst request is a put miss, plus a stalled result
   localparam int DRAIN_CYCLES    = 80;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int HOLD_CYCLES     = 300;
   localparam int POOL_SIZE       = 20;

   localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic              csr_index;
   logic [CSR_W-1:0]  csr_write_data;

   lrupe_req_if req_ch ();
   lrupe_rsp_if rsp_ch ();

   int                mismatch_count;
   int                results_outstanding;
   int                req_idle_pct = 0;
   int                rsp_idle_pct = 0;
   int                hold_requests = 0;
   int                cycle_count = 0;
   int                key_span = POOL_SIZE;
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];

   lru_cache_with_periodic_eviction_top #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   lru_cache_with_periodic_eviction_checker #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) cache_checker (
      .clock              (clock),
      .reset              (reset),
      .req_ch             (req_ch),
      .rsp_ch             (rsp_ch),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .results_outstanding(results_outstanding)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random back-pressure, plus a long hold-off on request
   initial begin : result_sink
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // mostly keys from a small pool so gets hit, the rest fully random
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 80)
         return key_pool[$urandom_range(key_span - 1)];
      return $urandom;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // one request transfer; valid stays up until ready is seen at an edge
   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      // occasional long gap so the next offer lands anywhere in a scan
      if (req_idle_pct > 0 && $urandom_range(99) < 3) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(48, 1)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.lookup_key <= key;
      req_ch.put_value  <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop offering, wait for every get result, then let a put scan finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (results_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers back to back; random upper bits on the capacity word
   task automatic configure(input logic [CAP_W-1:0] cap, input logic [INTV_W-1:0] interval);
      logic [CSR_W-1:0] word;
      int               span;
      word                = $urandom;
      word[CAP_W-1:0]     = cap;
      csr_write_enable   <= 1'b1;
      csr_index          <= CSR_IDX_CAPACITY;
      csr_write_data     <= word;
      @(posedge clock);
      csr_index          <= CSR_IDX_BURNOUT;
      csr_write_data     <= interval;
      @(posedge clock);
      csr_write_enable   <= 1'b0;
      // key pool a little wider than the usable capacity
      span = (cap == 0) ? 1 : ((cap > CACHE_ENTRIES) ? CACHE_ENTRIES : cap);
      key_span = (span + 4 > POOL_SIZE) ? POOL_SIZE : span + 4;
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0]  cap;
      logic [INTV_W-1:0] interval;

      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_IDX_CAPACITY;
      csr_write_data    <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= KIND_GET;
      req_ch.lookup_key <= '0;
      req_ch.put_value  <= '0;

      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 17;
      rsp_idle_pct = 69;

      // reset settings: extremes of key and value, update in place, miss on empty
      send_request(KIND_GET, '0, '1);
      send_request(KIND_PUT, KEY_MIN, KEY_MAX);
      send_request(KIND_PUT, KEY_MAX, KEY_MIN);
      send_request(KIND_PUT, '0, '1);
      send_request(KIND_PUT, '1, '0);
      send_request(KIND_GET, KEY_MIN, '0);
      send_request(KIND_GET, '0, KEY_MAX);
      send_request(KIND_PUT, KEY_MAX, 32'd5);
      send_request(KIND_GET, KEY_MAX, '1);
      send_request(KIND_GET, 32'd12345, '0);

      // capacity zero acts as one, and sits below the current occupancy
      settle();
      configure(5'd0, 16'd0);
      send_request(KIND_PUT, 32'd1, 32'd1);
      send_request(KIND_PUT, 32'd2, 32'd2);
      send_request(KIND_GET, 32'd1, '0);
      send_request(KIND_GET, 32'd2, '0);
      send_request(KIND_GET, '0, '0);

      // capacity saturates at the entry count; burnout on every request drains
      // the store and then evicts from an empty one
      settle();
      configure(5'd31, 16'd1);
      send_request(KIND_PUT, 32'd3, 32'd3);
      send_request(KIND_GET, 32'd3, '0);
      send_request(KIND_GET, 32'd1, '0);
      send_request(KIND_GET, 32'd2, '0);
      send_request(KIND_GET, '0, '0);
      send_request(KIND_GET, 32'd7, '0);

      // interval dropped under the running count burns out on the next request
      settle();
      configure(5'd16, 16'd40);
      send_request(KIND_PUT, 32'd9, 32'd9);
      send_request(KIND_PUT, 32'd8, 32'd8);
      send_request(KIND_GET, 32'd9, '0);
      settle();
      configure(5'd16, 16'd2);
      send_request(KIND_GET, 32'd8, '0);
      send_request(KIND_GET, 32'd9, '0);

      // random phases over a spread of settings, extremes included
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            0: begin cap = 5'd16; interval = 16'd0; end
            1: begin cap = 5'd1; interval = 16'd0; end
            2: begin cap = 5'd31; interval = 16'hffff; end
            3: begin cap = $urandom_range(15, 2); interval = $urandom_range(20, 2); end
            4: begin cap = 5'd0; interval = 16'd1; end
            5: begin cap = $urandom_range(31); interval = $urandom_range(40); end
            6: begin cap = 5'd8; interval = 16'd5; end
            default: begin cap = $urandom; interval = $urandom; end
         endcase
         configure(cap, interval);

         if (phase < 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 69;
         end else if (phase < 6) begin
            req_idle_pct = 69;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long result hold-off while requests keep coming: the block backs up
            if (phase == 1 && n == 60)
               hold_requests++;
            // sender pause until the result queue is empty
            if (phase == 4 && n == 100) begin
               req_ch.valid <= 1'b0;
               do @(posedge clock); while (results_outstanding != 0);
            end
            send_request(logic'($urandom_range(1)), pick_key(), pick_value());
         end
      end

      settle();
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
